// ===== hw/rtl/hvac_irtx_pkg.sv =====
// Shared types, constants and lookup tables for the IR frame transmitter.
// No dependencies; the interfaces, the transmitter and the testbench import this package.
package hvac_irtx_pkg;

  // Item operation codes
  localparam logic OP_CMD  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Configuration register indexes (byte address = 4 * index)
  localparam logic [2:0] REG_HDR_MARK  = 3'd0;
  localparam logic [2:0] REG_HDR_SPACE = 3'd1;
  localparam logic [2:0] REG_BIT_MARK  = 3'd2;
  localparam logic [2:0] REG_ONE_SPACE = 3'd3;
  localparam logic [2:0] REG_ZERO_SPC  = 3'd4;
  localparam logic [2:0] REG_GAP_SPACE = 3'd5;
  localparam logic [2:0] REG_MAX_SP    = 3'd6;
  localparam logic [2:0] REG_MIN_SP    = 3'd7;

  localparam int CFG_TICK_W = 15;
  localparam int BYTE_IDX_W = 5;

  localparam logic [CFG_TICK_W-1:0] RST_HDR_MARK  = 15'd3400;
  localparam logic [CFG_TICK_W-1:0] RST_HDR_SPACE = 15'd1750;
  localparam logic [CFG_TICK_W-1:0] RST_BIT_MARK  = 15'd450;
  localparam logic [CFG_TICK_W-1:0] RST_ONE_SPACE = 15'd1300;
  localparam logic [CFG_TICK_W-1:0] RST_ZERO_SPC  = 15'd420;
  localparam logic [CFG_TICK_W-1:0] RST_GAP_SPACE = 15'd17100;
  localparam logic [7:0]            RST_MAX_SP    = 8'd31;
  localparam logic [7:0]            RST_MIN_SP    = 8'd16;

  localparam logic [CFG_TICK_W-1:0] TRAILER_TICKS = 15'd440;

  localparam logic [7:0] SP_BASE       = 8'd16;
  localparam logic [7:0] POWER_ON_BYTE = 8'h20;
  localparam logic [7:0] POWER_OFF_BYTE = 8'h00;
  localparam logic [7:0] MODE_DEFAULT  = 8'h08;
  localparam logic [7:0] FAN_DEFAULT   = 8'h45;

  // Frame bytes that carry command fields
  localparam logic [BYTE_IDX_W-1:0] IDX_POWER = 5'd5;
  localparam logic [BYTE_IDX_W-1:0] IDX_MODE  = 5'd6;
  localparam logic [BYTE_IDX_W-1:0] IDX_TEMP  = 5'd7;
  localparam logic [BYTE_IDX_W-1:0] IDX_FAN   = 5'd9;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_HDR_MARK,
    PH_HDR_SPACE,
    PH_BIT_MARK,
    PH_BIT_SPACE,
    PH_TRAIL_MARK,
    PH_GAP
  } phase_e;

  typedef struct packed {
    logic       operation;
    logic       power_on;
    logic [2:0] hvac_mode;
    logic [7:0] setpoint;
    logic [2:0] fan_mode;
    logic [2:0] vane_mode;
  } in_item_t;

  typedef struct packed {
    logic ir_mark;
    logic busy_res;
    logic frame_done;
  } out_item_t;

  // Fixed frame template; entries past byte 17 are zero
  function automatic logic [7:0] tmpl_byte(input logic [BYTE_IDX_W-1:0] idx);
    logic [7:0] b;
    case (idx)
      5'd0:    b = 8'h23;
      5'd1:    b = 8'hCB;
      5'd2:    b = 8'h26;
      5'd3:    b = 8'h01;
      5'd5:    b = 8'h20;
      5'd6:    b = 8'h08;
      5'd7:    b = 8'h06;
      5'd8:    b = 8'h30;
      5'd9:    b = 8'h45;
      5'd10:   b = 8'h67;
      5'd17:   b = 8'h1F;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] mode_byte(input logic [2:0] mode);
    logic [7:0] b;
    case (mode)
      3'd0:    b = 8'h08;
      3'd1:    b = 8'h18;
      3'd2:    b = 8'h10;
      3'd3:    b = 8'h00;
      3'd4:    b = 8'h20;
      default: b = MODE_DEFAULT;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] fan_vane_byte(input logic [2:0] fan, input logic [2:0] vane);
    logic [7:0] f;
    logic [7:0] v;
    case (fan)
      3'd0:    f = 8'h01;
      3'd1:    f = 8'h02;
      3'd2:    f = 8'h03;
      3'd3:    f = 8'h04;
      3'd4:    f = 8'h04;
      3'd5:    f = 8'h80;
      3'd6:    f = 8'h05;
      default: f = FAN_DEFAULT;
    endcase
    case (vane)
      3'd0:    v = 8'h40;
      3'd1:    v = 8'h48;
      3'd2:    v = 8'h50;
      3'd3:    v = 8'h58;
      3'd4:    v = 8'h60;
      3'd5:    v = 8'h68;
      3'd6:    v = 8'h78;
      default: v = 8'h00;
    endcase
    return f | v;
  endfunction

endpackage

// ===== hw/rtl/hvac_irtx_in_if.sv =====
// Input item channel: valid/ready handshake carrying one command or tick item.
// Depends on hvac_irtx_pkg for the payload type.
interface hvac_irtx_in_if import hvac_irtx_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/hvac_irtx_out_if.sv =====
// Result item channel: valid/ready handshake carrying one envelope sample.
// Depends on hvac_irtx_pkg for the payload type.
interface hvac_irtx_out_if import hvac_irtx_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/hvac_irtx_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module hvac_irtx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 18
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/hvac_ir_frame_transmitter.sv =====
// Air-conditioner IR frame transmitter. A command item taken while idle loads a
// FRAME_BYTES-byte frame (template, power, mode, clamped setpoint, fan/vane bits
// and a trailing 8-bit checksum) into the frame memory, one byte per clock through
// its write port, and the input stalls until that load is done. Otherwise one
// item is taken every clock while the skid is empty: each tick item steps the mark
// envelope through header, LSB-first data bits, trailer and gap, SEND_COUNT times,
// and every item yields one result, held in an output register with a one-entry
// skid so one more item is taken while a result waits. Commands while busy are
// ignored. Segment lengths and setpoint limits sit in APB registers at 4*index.
module hvac_ir_frame_transmitter import hvac_irtx_pkg::*; #(
  parameter int FRAME_BYTES = 18,
  parameter int SEND_COUNT  = 2,
  parameter int TICK_WIDTH  = 15
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  hvac_irtx_in_if.sink           in_i,
  hvac_irtx_out_if.source        res_o,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [4:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  localparam int AW         = $clog2(FRAME_BYTES);
  localparam int BPW        = AW + 3;
  localparam int TOTAL_BITS = FRAME_BYTES * 8;
  localparam int SCW        = SEND_COUNT > 1 ? $clog2(SEND_COUNT) : 1;
  localparam int LW         = TICK_WIDTH > CFG_TICK_W ? TICK_WIDTH : CFG_TICK_W;
  localparam logic [AW-1:0]  LAST_BYTE = AW'(FRAME_BYTES - 1);
  localparam logic [BPW-1:0] LAST_BIT  = BPW'(TOTAL_BITS - 1);
  localparam logic [SCW-1:0] LAST_SEND = SCW'(SEND_COUNT - 1);

  // ---------------- configuration registers ----------------
  logic [CFG_TICK_W-1:0] hdr_mark_q, hdr_space_q, bit_mark_q;
  logic [CFG_TICK_W-1:0] one_space_q, zero_space_q, gap_space_q;
  logic [7:0]            max_sp_q, min_sp_q;
  logic                  cfg_wr;
  logic [2:0]            cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_mark_q   <= RST_HDR_MARK;
      hdr_space_q  <= RST_HDR_SPACE;
      bit_mark_q   <= RST_BIT_MARK;
      one_space_q  <= RST_ONE_SPACE;
      zero_space_q <= RST_ZERO_SPC;
      gap_space_q  <= RST_GAP_SPACE;
      max_sp_q     <= RST_MAX_SP;
      min_sp_q     <= RST_MIN_SP;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_HDR_MARK:  hdr_mark_q   <= pwdata[CFG_TICK_W-1:0];
        REG_HDR_SPACE: hdr_space_q  <= pwdata[CFG_TICK_W-1:0];
        REG_BIT_MARK:  bit_mark_q   <= pwdata[CFG_TICK_W-1:0];
        REG_ONE_SPACE: one_space_q  <= pwdata[CFG_TICK_W-1:0];
        REG_ZERO_SPC:  zero_space_q <= pwdata[CFG_TICK_W-1:0];
        REG_GAP_SPACE: gap_space_q  <= pwdata[CFG_TICK_W-1:0];
        REG_MAX_SP:    max_sp_q     <= pwdata[7:0];
        REG_MIN_SP:    min_sp_q     <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_HDR_MARK:  prdata = 32'(hdr_mark_q);
      REG_HDR_SPACE: prdata = 32'(hdr_space_q);
      REG_BIT_MARK:  prdata = 32'(bit_mark_q);
      REG_ONE_SPACE: prdata = 32'(one_space_q);
      REG_ZERO_SPC:  prdata = 32'(zero_space_q);
      REG_GAP_SPACE: prdata = 32'(gap_space_q);
      REG_MAX_SP:    prdata = 32'(max_sp_q);
      REG_MIN_SP:    prdata = 32'(min_sp_q);
      default:       prdata = '0;
    endcase
  end

  // ---------------- sequencer state ----------------
  phase_e           phase_q, phase_d;
  logic [TICK_WIDTH-1:0] tick_q, tick_d;
  logic [BPW-1:0]   bit_q, bit_d;
  logic [SCW-1:0]   send_q, send_d;
  logic             fill_q, fill_d;
  logic [AW-1:0]    fill_idx_q, fill_idx_d;
  logic [7:0]       sum_q, sum_d;
  logic             load;

  // command-derived frame bytes
  logic [7:0] b_power_q, b_mode_q, b_temp_q, b_fan_q;
  logic [7:0] sp_clamped;

  in_item_t in_data;
  logic     in_ready;
  logic     in_acc;
  logic     skid_valid_q;

  assign in_data   = in_i.data;
  assign in_ready  = !fill_q && !skid_valid_q;
  assign in_i.ready = in_ready;
  assign in_acc    = in_i.valid && in_ready;

  // ---------------- frame memory ----------------
  logic [BYTE_IDX_W-1:0] fill_idx_w;
  logic [7:0]            fill_byte;
  logic [7:0]            ram_rdata;
  logic                  bit_val;

  assign fill_idx_w = BYTE_IDX_W'(fill_idx_q);

  always_comb begin
    if (fill_idx_q == LAST_BYTE) begin
      fill_byte = sum_q;
    end else if (fill_idx_w == IDX_POWER) begin
      fill_byte = b_power_q;
    end else if (fill_idx_w == IDX_MODE) begin
      fill_byte = b_mode_q;
    end else if (fill_idx_w == IDX_TEMP) begin
      fill_byte = b_temp_q;
    end else if (fill_idx_w == IDX_FAN) begin
      fill_byte = b_fan_q;
    end else begin
      fill_byte = tmpl_byte(fill_idx_w);
    end
  end

  // Read address follows the current bit; a bit mark of at least one tick
  // always separates an address change from the space that uses the data.
  hvac_irtx_ram #(
    .WIDTH (8),
    .DEPTH (FRAME_BYTES)
  ) u_frame_ram (
    .clk_i   (clk_i),
    .we_i    (fill_q),
    .waddr_i (fill_idx_q),
    .wdata_i (fill_byte),
    .raddr_i (bit_q[BPW-1:3]),
    .rdata_o (ram_rdata)
  );

  assign bit_val = ram_rdata[bit_q[2:0]];

  // ---------------- segment timing ----------------
  logic [CFG_TICK_W-1:0] seg_raw;
  logic [LW-1:0]         seg_wide;
  logic [TICK_WIDTH-1:0] seg_len;
  logic [TICK_WIDTH:0]   tick_inc;
  logic                  seg_end;

  always_comb begin
    case (phase_q)
      PH_HDR_MARK:   seg_raw = hdr_mark_q;
      PH_HDR_SPACE:  seg_raw = hdr_space_q;
      PH_BIT_MARK:   seg_raw = bit_mark_q;
      PH_BIT_SPACE:  seg_raw = bit_val ? one_space_q : zero_space_q;
      PH_TRAIL_MARK: seg_raw = TRAILER_TICKS;
      default:       seg_raw = gap_space_q;
    endcase
  end

  assign seg_wide = LW'(seg_raw);
  assign seg_len  = seg_wide[TICK_WIDTH-1:0];
  assign tick_inc = {1'b0, tick_q} + 1'b1;
  // zero-length segments still last one tick
  assign seg_end  = tick_inc >= {1'b0, seg_len};

  // ---------------- next state ----------------
  always_comb begin
    phase_d    = phase_q;
    tick_d     = tick_q;
    bit_d      = bit_q;
    send_d     = send_q;
    fill_d     = fill_q;
    fill_idx_d = fill_idx_q;
    sum_d      = sum_q;
    load       = 1'b0;

    if (fill_q) begin
      sum_d      = sum_q + fill_byte;
      fill_idx_d = fill_idx_q + 1'b1;
      if (fill_idx_q == LAST_BYTE) begin
        fill_d     = 1'b0;
        fill_idx_d = '0;
      end
    end

    if (in_acc) begin
      if (in_data.operation == OP_CMD) begin
        if (phase_q == PH_IDLE) begin
          load       = 1'b1;
          phase_d    = PH_HDR_MARK;
          tick_d     = '0;
          bit_d      = '0;
          send_d     = '0;
          fill_d     = 1'b1;
          fill_idx_d = '0;
          sum_d      = '0;
        end
      end else if (phase_q != PH_IDLE) begin
        if (seg_end) begin
          tick_d = '0;
          case (phase_q)
            PH_HDR_MARK:  phase_d = PH_HDR_SPACE;
            PH_HDR_SPACE: begin
              phase_d = PH_BIT_MARK;
              bit_d   = '0;
            end
            PH_BIT_MARK:  phase_d = PH_BIT_SPACE;
            PH_BIT_SPACE: begin
              if (bit_q != LAST_BIT) begin
                bit_d   = bit_q + 1'b1;
                phase_d = PH_BIT_MARK;
              end else begin
                phase_d = PH_TRAIL_MARK;
              end
            end
            PH_TRAIL_MARK: phase_d = PH_GAP;
            default: begin
              if (send_q != LAST_SEND) begin
                send_d  = send_q + 1'b1;
                phase_d = PH_HDR_MARK;
              end else begin
                phase_d = PH_IDLE;
                send_d  = '0;
                bit_d   = '0;
              end
            end
          endcase
        end else begin
          tick_d = tick_inc[TICK_WIDTH-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      tick_q     <= '0;
      bit_q      <= '0;
      send_q     <= '0;
      fill_q     <= 1'b0;
      fill_idx_q <= '0;
      sum_q      <= '0;
    end else begin
      phase_q    <= phase_d;
      tick_q     <= tick_d;
      bit_q      <= bit_d;
      send_q     <= send_d;
      fill_q     <= fill_d;
      fill_idx_q <= fill_idx_d;
      sum_q      <= sum_d;
    end
  end

  // setpoint clamp: upper limit wins when the limits cross, unless the setpoint is at or below it
  always_comb begin
    if (in_data.setpoint > max_sp_q) begin
      sp_clamped = max_sp_q;
    end else if (in_data.setpoint < min_sp_q) begin
      sp_clamped = min_sp_q;
    end else begin
      sp_clamped = in_data.setpoint;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      b_power_q <= in_data.power_on ? POWER_ON_BYTE : POWER_OFF_BYTE;
      b_mode_q  <= mode_byte(in_data.hvac_mode);
      b_temp_q  <= sp_clamped - SP_BASE;
      b_fan_q   <= fan_vane_byte(in_data.fan_mode, in_data.vane_mode);
    end
  end

  // ---------------- result and output stage ----------------
  out_item_t res_d;

  always_comb begin
    res_d = '0;
    if (in_data.operation == OP_CMD) begin
      res_d.busy_res = 1'b1;
    end else if (phase_q != PH_IDLE) begin
      res_d.busy_res   = 1'b1;
      res_d.ir_mark    = (phase_q == PH_HDR_MARK) || (phase_q == PH_BIT_MARK) ||
                         (phase_q == PH_TRAIL_MARK);
      res_d.frame_done = seg_end && (phase_q == PH_GAP) && (send_q == LAST_SEND);
    end
  end

  logic      out_valid_q, out_valid_d, skid_valid_d;
  out_item_t out_q, skid_q;
  logic      out_take, out_load, skid_load, skid_move;

  assign out_take = out_valid_q && res_o.ready;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_load     = 1'b0;
    skid_load    = 1'b0;
    skid_move    = 1'b0;
    if (in_acc) begin
      // skid is empty whenever an item is taken
      if (!out_valid_q || res_o.ready) begin
        out_load    = 1'b1;
        out_valid_d = 1'b1;
      end else begin
        skid_load    = 1'b1;
        skid_valid_d = 1'b1;
      end
    end else if (out_take) begin
      if (skid_valid_q) begin
        skid_move    = 1'b1;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= res_d;
    end else if (skid_move) begin
      out_q <= skid_q;
    end
    if (skid_load) begin
      skid_q <= res_d;
    end
  end

  assign res_o.valid = out_valid_q;
  assign res_o.data  = out_q;

  // ---------------- assertions ----------------
  a_cmd_starts_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> fill_q && (phase_q == PH_HDR_MARK) && (fill_idx_q == '0))
    else $error("command taken while idle did not start the frame load");

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held with empty output register");

  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_IDLE) |-> (send_q == '0) && (bit_q == '0) && !fill_q)
    else $error("sequencer counters not cleared while idle");

  a_done_ends_send: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && res_d.frame_done) |=> (phase_q == PH_IDLE))
    else $error("frame done flagged without returning to idle");

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking bench for hvac_ir_frame_transmitter: command and tick items in,
// envelope samples out, each compared in order against an in-bench predictor.
// Depends on hvac_irtx_pkg, the two item channel interfaces and the transmitter.
module testbench;
  import hvac_irtx_pkg::*;

  localparam int     FRAME_LEN   = 18;
  localparam int     SENDS       = 2;
  localparam int     FRAME_BITS  = FRAME_LEN * 8;
  localparam int     TRAIL_LEN   = 440;
  localparam int     SP_FLOOR    = 16;
  localparam int     HOLD_CYCLES = 300;
  localparam int     END_WAIT    = 40;
  localparam int     RAND_PHASES = 10;
  localparam longint CYCLE_LIMIT = 2_000_000;

  localparam logic [7:0] TEMPLATE [FRAME_LEN] = '{
    8'h23, 8'hCB, 8'h26, 8'h01, 8'h00, 8'h20, 8'h08, 8'h06, 8'h30,
    8'h45, 8'h67, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
  localparam logic [7:0] MODE_BITS [5] = '{8'h08, 8'h18, 8'h10, 8'h00, 8'h20};
  localparam logic [7:0] FAN_BITS  [7] = '{8'h01, 8'h02, 8'h03, 8'h04, 8'h04, 8'h80, 8'h05};
  localparam logic [7:0] VANE_BITS [7] = '{8'h40, 8'h48, 8'h50, 8'h58, 8'h60, 8'h68, 8'h78};
  localparam logic [7:0] PWR_ON     = 8'h20;
  localparam logic [7:0] PWR_OFF    = 8'h00;
  localparam logic [7:0] FAN_KEEP   = 8'h45;

  typedef logic [31:0] reg_set_t [8];
  localparam reg_set_t RESET_VALUES = '{3400, 1750, 450, 1300, 420, 17100, 31, 16};

  localparam out_item_t RES_IDLE = 3'b000;
  localparam out_item_t RES_BUSY = 3'b010;
  localparam out_item_t RES_MARK = 3'b110;

  typedef struct packed {
    in_item_t   item;
    logic [3:0] count;   // 0: keep ticking until the frame has gone out
    logic       typed;
    out_item_t  res;
  } drill_row_t;

  localparam drill_row_t DRILL [13] = '{
    '{'{OP_TICK, 1'b0, 3'd0, 8'd0,   3'd0, 3'd0}, 4'd2, 1'b1, RES_IDLE},
    '{'{OP_TICK, 1'b1, 3'd7, 8'd255, 3'd7, 3'd7}, 4'd1, 1'b1, RES_IDLE},
    '{'{OP_CMD,  1'b1, 3'd0, 8'd0,   3'd0, 3'd0}, 4'd1, 1'b1, RES_BUSY}, // clamps up to min
    '{'{OP_CMD,  1'b0, 3'd7, 8'd255, 3'd7, 3'd7}, 4'd1, 1'b1, RES_BUSY}, // dropped, busy
    '{'{OP_TICK, 1'b0, 3'd0, 8'd0,   3'd0, 3'd0}, 4'd1, 1'b1, RES_MARK}, // header mark
    '{'{OP_TICK, 1'b0, 3'd0, 8'd0,   3'd0, 3'd0}, 4'd0, 1'b0, RES_IDLE},
    '{'{OP_TICK, 1'b1, 3'd5, 8'd77,  3'd2, 3'd1}, 4'd1, 1'b1, RES_IDLE},
    '{'{OP_CMD,  1'b0, 3'd7, 8'd255, 3'd7, 3'd7}, 4'd1, 1'b1, RES_BUSY}, // defaults, max
    '{'{OP_TICK, 1'b0, 3'd0, 8'd0,   3'd0, 3'd0}, 4'd0, 1'b0, RES_IDLE},
    '{'{OP_CMD,  1'b1, 3'd4, 8'd17,  3'd6, 3'd6}, 4'd1, 1'b1, RES_BUSY},
    '{'{OP_TICK, 1'b0, 3'd0, 8'd0,   3'd0, 3'd0}, 4'd0, 1'b0, RES_IDLE},
    '{'{OP_CMD,  1'b0, 3'd3, 8'd30,  3'd5, 3'd0}, 4'd1, 1'b1, RES_BUSY},
    '{'{OP_TICK, 1'b0, 3'd0, 8'd0,   3'd0, 3'd0}, 4'd0, 1'b0, RES_IDLE}
  };

  logic        clk_i   = 1'b0;
  logic        rst_ni  = 1'b0;
  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [4:0]  paddr   = '0;
  logic [31:0] pwdata  = '0;
  logic [31:0] prdata;
  logic        pready;

  hvac_irtx_in_if  in_if ();
  hvac_irtx_out_if res_if ();

  hvac_ir_frame_transmitter u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .res_o   (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #4 clk_i = ~clk_i;

  // Predictor state and register copy
  logic [31:0] reg_model [8];
  logic [7:0]  frame_q [FRAME_LEN];
  phase_e      m_phase = PH_IDLE;
  int unsigned m_bit   = 0;
  int unsigned m_send  = 0;
  int unsigned m_ticks = 0;

  out_item_t   envelope_q [$];
  int          errors          = 0;
  int          items_sent      = 0;
  int          results_checked = 0;
  int          frames_seen     = 0;
  int          dropped_cmds    = 0;
  int          settings_loaded = 0;
  longint      cycles          = 0;
  bit          quiet           = 1'b0;
  bit          hold_req        = 1'b0;

  function automatic void compose_frame(input in_item_t it);
    logic [7:0] sp;
    logic [7:0] fan_vane;
    logic [7:0] sum;
    for (int i = 0; i < FRAME_LEN; i++) frame_q[i] = TEMPLATE[i];
    frame_q[5] = it.power_on ? PWR_ON : PWR_OFF;
    if (it.hvac_mode < $size(MODE_BITS)) frame_q[6] = MODE_BITS[it.hvac_mode];
    // max is tested first, so min above max wins only at or below max
    sp = it.setpoint;
    if (sp > reg_model[REG_MAX_SP][7:0]) sp = reg_model[REG_MAX_SP][7:0];
    else if (sp < reg_model[REG_MIN_SP][7:0]) sp = reg_model[REG_MIN_SP][7:0];
    frame_q[7] = sp - 8'(SP_FLOOR);
    fan_vane = FAN_KEEP;
    if (it.fan_mode < $size(FAN_BITS)) fan_vane = FAN_BITS[it.fan_mode];
    if (it.vane_mode < $size(VANE_BITS)) fan_vane |= VANE_BITS[it.vane_mode];
    frame_q[9] = fan_vane;
    sum = '0;
    for (int i = 0; i < FRAME_LEN - 1; i++) sum += frame_q[i];
    frame_q[FRAME_LEN-1] = sum;
  endfunction

  function automatic int unsigned segment_ticks();
    case (m_phase)
      PH_HDR_MARK:   return reg_model[REG_HDR_MARK];
      PH_HDR_SPACE:  return reg_model[REG_HDR_SPACE];
      PH_BIT_MARK:   return reg_model[REG_BIT_MARK];
      PH_BIT_SPACE:  return frame_q[m_bit / 8][m_bit % 8] ? reg_model[REG_ONE_SPACE]
                                                          : reg_model[REG_ZERO_SPC];
      PH_TRAIL_MARK: return TRAIL_LEN;
      default:       return reg_model[REG_GAP_SPACE];
    endcase
  endfunction

  function automatic out_item_t envelope_step(input in_item_t it);
    out_item_t r;
    r = RES_IDLE;
    if (it.operation == OP_CMD) begin
      if (m_phase == PH_IDLE) begin
        compose_frame(it);
        m_phase = PH_HDR_MARK;
        m_bit   = 0;
        m_send  = 0;
        m_ticks = 0;
      end else begin
        dropped_cmds++;
      end
      r.busy_res = 1'b1;
    end else if (m_phase != PH_IDLE) begin
      r.busy_res = 1'b1;
      r.ir_mark  = m_phase inside {PH_HDR_MARK, PH_BIT_MARK, PH_TRAIL_MARK};
      // a zero-length segment still takes one tick
      if (m_ticks + 1 >= segment_ticks()) begin
        m_ticks = 0;
        case (m_phase)
          PH_HDR_MARK:   m_phase = PH_HDR_SPACE;
          PH_HDR_SPACE: begin
            m_phase = PH_BIT_MARK;
            m_bit   = 0;
          end
          PH_BIT_MARK:   m_phase = PH_BIT_SPACE;
          PH_BIT_SPACE: begin
            if (m_bit + 1 < FRAME_BITS) begin
              m_bit++;
              m_phase = PH_BIT_MARK;
            end else begin
              m_phase = PH_TRAIL_MARK;
            end
          end
          PH_TRAIL_MARK: m_phase = PH_GAP;
          default: begin
            if (m_send + 1 < SENDS) begin
              m_send++;
              m_phase = PH_HDR_MARK;
            end else begin
              m_phase      = PH_IDLE;
              m_send       = 0;
              m_bit        = 0;
              r.frame_done = 1'b1;
            end
          end
        endcase
      end else begin
        m_ticks++;
      end
    end
    return r;
  endfunction

  function automatic in_item_t random_fields(input logic op);
    logic [31:0] raw;
    in_item_t    it;
    raw = $urandom;
    it = raw[$bits(in_item_t)-1:0];
    it.operation = op;
    return it;
  endfunction

  task automatic offer(input in_item_t it, input logic typed, input out_item_t typed_res);
    int unsigned gap;
    out_item_t   predicted;
    gap = quiet ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= it;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    predicted = envelope_step(it);
    envelope_q.push_back(typed ? typed_res : predicted);
    items_sent++;
  endtask

  // stop offering and let every outstanding result come back
  task automatic drain();
    in_if.valid <= 1'b0;
    while (envelope_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic apb_access(input logic wr, input logic [2:0] idx, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic check_reg(input logic [2:0] idx);
    logic [31:0] got;
    apb_access(1'b0, idx, '0, got);
    if (got !== reg_model[idx]) begin
      $display("%0t: register %0d expected %0d got %0d", $time, idx, reg_model[idx], got);
      errors++;
    end
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    logic [31:0] mask;
    logic [31:0] unused;
    mask = (idx < REG_MAX_SP) ? 32'h7FFF : 32'hFF;
    // junk above the register width must be dropped
    apb_access(1'b1, idx, value | ($urandom & ~mask), unused);
    reg_model[idx] = value & mask;
    check_reg(idx);
  endtask

  task automatic apply_config(input reg_set_t vals);
    for (int i = 0; i < $size(vals); i++) write_reg(3'(i), vals[i]);
    settings_loaded++;
  endtask

  task automatic check_bit(input string field, input logic want, input logic got);
    if (got !== want) begin
      $display("%0t: %s expected %b got %b", $time, field, want, got);
      errors++;
    end
  endtask

  always @(posedge clk_i) cycles <= cycles + 1;

  initial begin
    wait (cycles >= CYCLE_LIMIT);
    $display("testbench: FAIL");
    $finish;
  end

  // result side
  initial begin
    int unsigned gap;
    out_item_t   want;
    res_if.ready = 1'b0;
    wait (rst_ni);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        gap = HOLD_CYCLES;
      end else begin
        gap = quiet ? 0 : $urandom_range(0, 7);
      end
      if (gap > 0) begin
        res_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      res_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!res_if.valid) @(posedge clk_i);
      if (envelope_q.size() == 0) begin
        $display("%0t: result %b with nothing expected", $time, res_if.data);
        errors++;
      end else begin
        want = envelope_q.pop_front();
        check_bit("ir_mark", want.ir_mark, res_if.data.ir_mark);
        check_bit("busy_res", want.busy_res, res_if.data.busy_res);
        check_bit("frame_done", want.frame_done, res_if.data.frame_done);
        if (want.frame_done) frames_seen++;
        results_checked++;
      end
    end
  end

  // stimulus
  initial begin
    reg_set_t settings;
    int       n;
    in_if.valid = 1'b0;
    in_if.data  = '0;
    reg_model   = RESET_VALUES;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int i = 0; i < $size(reg_model); i++) check_reg(3'(i));

    // short segments so a whole frame fits in a couple of thousand ticks
    settings = '{3, 2, 1, 3, 1, 2, 30, 17};
    apply_config(settings);

    for (int r = 0; r < $size(DRILL); r++) begin
      if (DRILL[r].count == 0) begin
        while (m_phase != PH_IDLE) offer(random_fields(OP_TICK), 1'b0, RES_IDLE);
      end else begin
        repeat (DRILL[r].count) offer(DRILL[r].item, DRILL[r].typed, DRILL[r].res);
      end
    end

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      drain();
      case (ph)
        0: settings = '{0, 0, 0, 0, 0, 0, 16, 255};     // zero lengths, min above max
        1: settings = '{32767, 0, 0, 0, 0, 0, 255, 16}; // longest header
        default: begin
          foreach (settings[i]) settings[i] = $urandom_range(0, 3);
          settings[REG_ONE_SPACE] = $urandom_range(0, 6);
          settings[REG_ZERO_SPC]  = $urandom_range(0, 6);
          settings[REG_MAX_SP]    = $urandom_range(16, 255);
          settings[REG_MIN_SP]    = $urandom_range(16, 255);
        end
      endcase
      apply_config(settings);
      quiet = (ph == 1) || (ph == 4);
      repeat ($urandom_range(0, 3)) offer(random_fields(OP_TICK), 1'b0, RES_IDLE);
      offer(random_fields(OP_CMD), 1'b0, RES_IDLE);
      n = 0;
      // mostly ticks, with the odd command that must be dropped
      while (m_phase != PH_IDLE) begin
        if (ph == 2 && n == 100) hold_req = 1'b1;
        offer(random_fields(($urandom_range(0, 31) == 0) ? OP_CMD : OP_TICK), 1'b0, RES_IDLE);
        n++;
      end
      repeat ($urandom_range(0, 3)) offer(random_fields(OP_TICK), 1'b0, RES_IDLE);
      quiet = 1'b0;
    end

    drain();
    repeat (END_WAIT) @(posedge clk_i);
    $display("run: %0d items sent (%0d commands dropped while busy), %0d results checked",
             items_sent, dropped_cmds, results_checked);
    $display("run: %0d frames sent out under %0d register settings",
             frames_seen, settings_loaded);
    if (errors == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/hvac_irtx_pkg.sv
hw/rtl/hvac_irtx_in_if.sv
hw/rtl/hvac_irtx_out_if.sv
hw/rtl/hvac_irtx_ram.sv
hw/rtl/hvac_ir_frame_transmitter.sv
sim/testbench.sv
